### rtl/tada_pkg.sv
// tada_pkg: shared codes, register defaults and controller command struct
// for the teleop / autonomous drive arbiter. No dependencies.
`timescale 1ns / 1ps
package tada_pkg;

    // fixed field widths
    localparam int STICK_W = 14;
    localparam int LIMIT_W = 15;
    localparam int DZ_W    = 13;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W = 2;

    // request command codes
    localparam logic [CMD_W-1:0] CMD_AUTO = 2'd0;
    localparam logic [CMD_W-1:0] CMD_JOY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 2'd1;

    // register defaults, Q4.12
    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET = 15'd18432;
    localparam logic [DZ_W-1:0]    DEAD_ZONE_RESET   = 13'd614;

    // controller to datapath commands
    typedef struct packed {
        logic busy;
        logic start;
        logic mul;
        logic step;
        logic finish;
    } ctl_t;

endpackage

### rtl/tada_ctrl.sv
// tada_ctrl: sequencer for the speed-limit scaling (multiply, divide, write back).
// Depends on tada_pkg for the command struct.
`timescale 1ns / 1ps
module tada_ctrl
    import tada_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  logic scale_req,
    output ctl_t ctl
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // next state and divider step count
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && scale_req)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV;
                cnt_next   = CNT_W'(VALUE_WIDTH - 1);
            end
            S_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // command decode
    always_comb
    begin
        ctl.busy   = (state_reg != S_IDLE);
        ctl.start  = (state_reg == S_IDLE) && accept && scale_req;
        ctl.mul    = (state_reg == S_MUL);
        ctl.step   = (state_reg == S_DIV);
        ctl.finish = (state_reg == S_DONE);
    end

    // checks
    a_start_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> (state_reg == S_MUL))
        else $error("scaling start did not enter multiply");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == '0) |=> (state_reg == S_DONE))
        else $error("divider did not finish after last step");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !ctl.busy)
        else $error("request accepted while scaling in progress");

endmodule

### rtl/tada_dp.sv
// tada_dp: held commands, mode toggle, deadzone, scaling multiplier and
// restoring divider, output register. Depends on tada_pkg and tada_ctrl commands.
`timescale 1ns / 1ps
module tada_dp
    import tada_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctl_t                          ctl,
    input  logic                          accept,
    input  logic [CMD_W-1:0]              cmd,
    input  logic signed [VALUE_WIDTH-1:0] auto_linear,
    input  logic signed [VALUE_WIDTH-1:0] auto_angular,
    input  logic signed [STICK_W-1:0]     stick_forward,
    input  logic signed [STICK_W-1:0]     stick_turn,
    input  logic signed [STICK_W-1:0]     deadman_axis,
    input  logic                          mode_button,
    input  logic [LIMIT_W-1:0]            speed_limit,
    input  logic [DZ_W-1:0]               dead_zone,
    input  logic                          out_stall,
    output logic                          scale_req,
    output logic                          out_valid,
    output logic signed [VALUE_WIDTH-1:0] drive_linear,
    output logic signed [VALUE_WIDTH-1:0] drive_angular,
    output logic                          auto_mode
);

    localparam int VW    = VALUE_WIDTH;
    localparam int CMP_W = ((VW > LIMIT_W) ? VW : LIMIT_W) + 1;
    localparam int EXT_W = ((VW > STICK_W) ? VW : STICK_W) + 1;
    localparam int PW    = 2 * VW + LIMIT_W;
    localparam logic signed [EXT_W-1:0] VHI =
        $signed({{(EXT_W - VW + 1){1'b0}}, {(VW - 1){1'b1}}});
    localparam logic signed [EXT_W-1:0] VLO = ~VHI;

    // held commands and mode
    logic [VW-1:0] held_auto_lin_reg;
    logic [VW-1:0] held_auto_ang_reg;
    logic [VW-1:0] held_joy_lin_reg;
    logic [VW-1:0] held_joy_ang_reg;
    logic          prev_button_reg;
    logic          auto_flag_reg;

    // scaling operands and divider
    logic [VW-1:0]      cap_lin_reg;
    logic [VW-1:0]      cap_mag_reg;
    logic [LIMIT_W-1:0] cap_lim_reg;
    logic               cap_neg_reg;
    logic [VW-1:0]      rem_reg;
    logic [VW-1:0]      quo_reg;

    // output register
    logic          out_valid_reg;
    logic [VW-1:0] out_lin_reg;
    logic [VW-1:0] out_ang_reg;
    logic          out_mode_reg;

    logic [CMP_W-1:0] lin_ext;
    logic [CMP_W-1:0] lim_ext;
    logic [VW-1:0]    ang_mag;
    logic [PW-1:0]    prod;
    logic [VW:0]      trial;
    logic [VW-1:0]    fwd_dz;
    logic [VW-1:0]    trn_dz;
    logic             is_auto;
    logic             is_joy;
    logic             is_tick;

    // deadzone on true magnitude, then saturate into the value width
    function automatic logic [VW-1:0] dz_axis(input logic [STICK_W-1:0] a,
                                              input logic [DZ_W-1:0] dz);
        logic [STICK_W-1:0]      mag;
        logic signed [EXT_W-1:0] ext;
        mag = a[STICK_W-1] ? (~a + 1'b1) : a;
        ext = $signed({{(EXT_W - STICK_W){a[STICK_W-1]}}, a});
        if (mag < {1'b0, dz})
        begin
            dz_axis = '0;
        end
        else if (ext > VHI)
        begin
            dz_axis = VHI[VW-1:0];
        end
        else if (ext < VLO)
        begin
            dz_axis = VLO[VW-1:0];
        end
        else
        begin
            dz_axis = ext[VW-1:0];
        end
    endfunction

    // request decode and limit compare
    always_comb
    begin
        is_auto   = accept && (cmd == CMD_AUTO);
        is_joy    = accept && (cmd == CMD_JOY);
        is_tick   = accept && (cmd == CMD_TICK);
        lin_ext   = {{(CMP_W - VW){auto_linear[VW-1]}}, auto_linear};
        lim_ext   = {{(CMP_W - LIMIT_W){1'b0}}, speed_limit};
        scale_req = (cmd == CMD_AUTO) && ($signed(lin_ext) > $signed(lim_ext));
        ang_mag   = auto_angular[VW-1] ? (~auto_angular + 1'b1) : auto_angular;
        fwd_dz    = dz_axis(stick_forward, dead_zone);
        trn_dz    = dz_axis(stick_turn, dead_zone);
    end

    // multiplier and divider trial subtract
    assign prod  = PW'(cap_mag_reg) * PW'(cap_lim_reg);
    assign trial = {rem_reg, quo_reg[VW-1]} - {1'b0, cap_lin_reg};

    // scaling operand capture
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            cap_lin_reg <= auto_linear;
            cap_mag_reg <= ang_mag;
            cap_lim_reg <= speed_limit;
            cap_neg_reg <= auto_angular[VW-1];
        end
    end

    // product preload then one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            rem_reg <= prod[2*VW-1:VW];
            quo_reg <= prod[VW-1:0];
        end
        else if (ctl.step)
        begin
            if (!trial[VW])
            begin
                rem_reg <= trial[VW-1:0];
                quo_reg <= {quo_reg[VW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[VW-2:0], quo_reg[VW-1]};
                quo_reg <= {quo_reg[VW-2:0], 1'b0};
            end
        end
    end

    // held state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_auto_lin_reg <= '0;
            held_auto_ang_reg <= '0;
            held_joy_lin_reg  <= '0;
            held_joy_ang_reg  <= '0;
            prev_button_reg   <= 1'b0;
            auto_flag_reg     <= 1'b0;
        end
        else
        begin
            if (is_auto && !scale_req)
            begin
                held_auto_lin_reg <= auto_linear;
                held_auto_ang_reg <= auto_angular;
            end
            else if (ctl.finish)
            begin
                held_auto_lin_reg <= VW'(cap_lim_reg);
                held_auto_ang_reg <= cap_neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            end
            if (is_joy)
            begin
                if (mode_button && !prev_button_reg)
                begin
                    auto_flag_reg <= ~auto_flag_reg;
                end
                prev_button_reg <= mode_button;
                if (deadman_axis[STICK_W-1])
                begin
                    held_joy_lin_reg <= fwd_dz;
                    held_joy_ang_reg <= trn_dz;
                end
                else
                begin
                    held_joy_lin_reg <= '0;
                    held_joy_ang_reg <= '0;
                end
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (is_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (is_tick)
        begin
            out_lin_reg  <= auto_flag_reg ? held_auto_lin_reg : held_joy_lin_reg;
            out_ang_reg  <= auto_flag_reg ? held_auto_ang_reg : held_joy_ang_reg;
            out_mode_reg <= auto_flag_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_linear  = out_lin_reg;
    assign drive_angular = out_ang_reg;
    assign auto_mode     = out_mode_reg;

    // checks
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> (rem_reg < cap_lin_reg))
        else $error("divider remainder not below divisor");

    a_quo_not_grown: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> (quo_reg <= cap_mag_reg))
        else $error("scaled turn rate grew in magnitude");

    a_tick_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        is_tick |-> !out_valid_reg)
        else $error("tick accepted while output register full");

endmodule

### rtl/teleop_auto_drive_arbiter_top.sv
// A tick request raises out_valid in the cycle after acceptance.
// Joystick and in-limit autonomous requests can be accepted back to back; a tick is held
// off while out_valid is high; an autonomous request over the speed limit stalls requests
// while it is scaled (multiply, VALUE_WIDTH divider steps, write-back).
// Reset (rst_n, asynchronous): held commands zero, joystick mode, button history
// cleared, speed_limit and dead_zone back to 4.5 and 0.15.
`timescale 1ns / 1ps
module teleop_auto_drive_arbiter_top
    import tada_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CMD_W-1:0]              cmd,
    input  logic signed [VALUE_WIDTH-1:0] auto_linear,
    input  logic signed [VALUE_WIDTH-1:0] auto_angular,
    input  logic signed [STICK_W-1:0]     stick_forward,
    input  logic signed [STICK_W-1:0]     stick_turn,
    input  logic signed [STICK_W-1:0]     deadman_axis,
    input  logic                          mode_button,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] drive_linear,
    output logic signed [VALUE_WIDTH-1:0] drive_angular,
    output logic                          auto_mode,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [LIMIT_W-1:0]            cfg_data
);

    ctl_t               ctl;
    logic               accept;
    logic               scale_req;
    logic [LIMIT_W-1:0] speed_limit_reg;
    logic [DZ_W-1:0]    dead_zone_reg;

    // request handshake: hold off while scaling or while a tick has no output slot
    assign in_stall  = ctl.busy || (out_valid && (cmd == CMD_TICK));
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= SPEED_LIMIT_RESET;
            dead_zone_reg   <= DEAD_ZONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data;
                CFG_DEAD_ZONE:   dead_zone_reg   <= cfg_data[DZ_W-1:0];
                default:         ;
            endcase
        end
    end

    // controller
    tada_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .scale_req (scale_req),
        .ctl       (ctl)
    );

    // datapath
    tada_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .accept        (accept),
        .cmd           (cmd),
        .auto_linear   (auto_linear),
        .auto_angular  (auto_angular),
        .stick_forward (stick_forward),
        .stick_turn    (stick_turn),
        .deadman_axis  (deadman_axis),
        .mode_button   (mode_button),
        .speed_limit   (speed_limit_reg),
        .dead_zone     (dead_zone_reg),
        .out_stall     (out_stall),
        .scale_req     (scale_req),
        .out_valid     (out_valid),
        .drive_linear  (drive_linear),
        .drive_angular (drive_angular),
        .auto_mode     (auto_mode)
    );

endmodule
